// File: sv/lclm_pkg.sv
// Package for the lock contention latency monitor: status codes, flag bits,
// table entry layout. No dependencies.
`default_nettype none
package lclm_pkg;
  localparam logic [7:0] FLAG_SPIN  = 8'h01;
  localparam logic [7:0] FLAG_READ  = 8'h02;
  localparam logic [7:0] FLAG_WRITE = 8'h04;

  localparam logic [2:0] ST_BEGUN    = 3'd0;
  localparam logic [2:0] ST_BUSY     = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_RECORDED = 3'd3;
  localparam logic [2:0] ST_NOMATCH  = 3'd4;
  localparam logic [2:0] ST_NEGATIVE = 3'd5;

  typedef struct packed {
    logic [31:0] task_id;
    logic [63:0] start;
    logic [63:0] lock;
    logic [7:0]  kind;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic is_spin_kind(input logic [7:0] f);
    return (f == FLAG_SPIN) || (f == (FLAG_SPIN | FLAG_READ)) ||
           (f == (FLAG_SPIN | FLAG_WRITE));
  endfunction
endpackage
`default_nettype wire

// File: sv/lclm_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module lclm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: sv/lock_contention_latency_monitor.sv
// Top level of the lock contention latency monitor.
// Uses lclm_pkg and one lclm_ram holding the pending task table.
//
//  channel | ports                                              | dir
//  in      | in_valid in_stall in_operation in_task_id ...      | in
//  out     | out_valid out_stall out_status ... out_last_flags  | out
//
// A spin event, or an end with the spin slot busy, goes from SCAN straight to
// EXEC and OUT. A table event scans entries one per cycle through the RAM's
// single port until the task is found or all ENTRIES have been read, then
// passes through CHECK, EXEC and OUT before its result is valid.
// Valid bits sit in flip-flops cleared by reset; no clearing pass.
// The input stalls while a result waits; the next item is taken the cycle
// after the result is taken.
`default_nettype none
module lock_contention_latency_monitor #(
  parameter int ENTRIES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_operation,
  input  wire logic [31:0] in_task_id,
  input  wire logic [63:0] in_lock_addr,
  input  wire logic [7:0]  in_lock_flags,
  input  wire logic [63:0] in_now_ns,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [63:0]      out_duration_ns,
  output logic [31:0]      out_sample_count,
  output logic [63:0]      out_total_ns,
  output logic [63:0]      out_min_ns,
  output logic [63:0]      out_max_ns,
  output logic [7:0]       out_last_flags
);
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RD = (ENTRIES > 1) ? ENTRIES : 2;
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_CHECK = 5'b00100,
    S_EXEC  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic        op_r;
  logic [31:0] task_r;
  logic [63:0] lock_r, now_r;
  logic [7:0]  kind_r;

  logic [63:0] spin_start_r, spin_lock_r;
  logic [7:0]  spin_kind_r;
  logic [ENTRIES-1:0] valid_r;
  logic [31:0] count_r;
  logic [63:0] total_r, min_r, max_r;
  logic [7:0]  flags_r;

  logic [CW-1:0] scan_r;      // index being read
  logic          found_r;
  logic [AW-1:0] hit_r;
  logic          free_ok_r;
  logic [AW-1:0] free_r;
  logic          pend_r;      // a read is in flight for scan_r-1

  logic          ov_r;
  logic [2:0]    st_r;
  logic [63:0]   dur_r;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  lclm_pkg::entry_t ram_wd, ram_rd;

  lclm_ram #(.WIDTH(lclm_pkg::ENTRY_W), .DEPTH(RD)) u_table (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
  );

  logic [AW-1:0] prev_idx;
  assign prev_idx = AW'(scan_r - CW'(1));

  logic take, deliver;
  assign deliver  = ov_r && !out_stall;
  // result and statistics ports must hold while a result waits
  assign in_stall = (state_r != S_IDLE) || ov_r;
  assign take     = in_valid && !in_stall;

  // end event arithmetic
  logic [63:0] e_start, e_dur;
  logic [7:0]  e_kind;
  logic        use_spin;
  assign use_spin = (spin_lock_r != 64'd0);
  assign e_start  = use_spin ? spin_start_r : ram_rd.start;
  assign e_kind   = use_spin ? spin_kind_r : ram_rd.kind;
  assign e_dur    = now_r - e_start;

  logic tbl_match;
  assign tbl_match = found_r && (ram_rd.lock == lock_r);

  always_comb begin
    state_nxt = state_r;
    ram_we    = 1'b0;
    ram_addr  = scan_r[AW-1:0];
    ram_wd    = '{task_id: task_r, start: now_r, lock: lock_r, kind: kind_r};
    unique case (state_r)
      S_IDLE:  if (take) state_nxt = S_SCAN;
      S_SCAN: begin
        if (!op_r && lclm_pkg::is_spin_kind(kind_r)) state_nxt = S_EXEC;
        else if (op_r && use_spin) state_nxt = S_EXEC;
        else if (found_r || (scan_r == CW'(ENTRIES) && !pend_r))
          state_nxt = S_CHECK;
      end
      S_CHECK: begin
        ram_addr  = found_r ? hit_r : free_r;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        ram_addr = found_r ? hit_r : free_r;
        if (!op_r && !lclm_pkg::is_spin_kind(kind_r)) begin
          if (found_r) ram_we = (ram_rd.lock == 64'd0);
          else         ram_we = free_ok_r;
        end
        state_nxt = S_OUT;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      spin_start_r <= '0;
      spin_lock_r  <= '0;
      spin_kind_r  <= '0;
      valid_r      <= '0;
      count_r      <= '0;
      total_r      <= '0;
      min_r        <= '0;
      max_r        <= '0;
      flags_r      <= '0;
      ov_r         <= 1'b0;
      scan_r       <= '0;
      found_r      <= 1'b0;
      free_ok_r    <= 1'b0;
      pend_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (deliver) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (take) begin
          op_r <= in_operation; task_r <= in_task_id; lock_r <= in_lock_addr;
          kind_r <= in_lock_flags; now_r <= in_now_ns;
          scan_r <= '0; found_r <= 1'b0; free_ok_r <= 1'b0; pend_r <= 1'b0;
        end
        S_SCAN: begin
          // compare the entry read last cycle; skip invalid slots
          if (pend_r && valid_r[prev_idx] && ram_rd.task_id == task_r
              && !found_r) begin
            found_r <= 1'b1; hit_r <= prev_idx;
          end
          if (scan_r != CW'(ENTRIES)) begin
            if (!valid_r[scan_r[AW-1:0]] && !free_ok_r) begin
              free_ok_r <= 1'b1; free_r <= scan_r[AW-1:0];
            end
            scan_r <= scan_r + CW'(1);
            pend_r <= 1'b1;
          end else begin
            pend_r <= 1'b0;
          end
        end
        S_EXEC: begin
          dur_r <= '0;
          if (!op_r) begin
            if (lclm_pkg::is_spin_kind(kind_r)) begin
              if (use_spin) st_r <= lclm_pkg::ST_BUSY;
              else begin
                st_r <= lclm_pkg::ST_BEGUN;
                spin_start_r <= now_r; spin_lock_r <= lock_r;
                spin_kind_r <= kind_r;
              end
            end else if (found_r) begin
              st_r <= (ram_rd.lock != 64'd0) ? lclm_pkg::ST_BUSY
                                             : lclm_pkg::ST_BEGUN;
            end else if (free_ok_r) begin
              st_r <= lclm_pkg::ST_BEGUN;
              valid_r[free_r] <= 1'b1;
            end else begin
              st_r <= lclm_pkg::ST_FULL;
            end
          end else if (use_spin ? (spin_lock_r == lock_r) : tbl_match) begin
            if (e_dur[63]) st_r <= lclm_pkg::ST_NEGATIVE;
            else begin
              st_r  <= lclm_pkg::ST_RECORDED;
              dur_r <= e_dur;
              flags_r <= e_kind;
              if (count_r == 32'd0) begin
                total_r <= e_dur; min_r <= e_dur; max_r <= e_dur;
                count_r <= 32'd1;
              end else begin
                total_r <= total_r + e_dur;
                if (count_r != 32'hFFFF_FFFF) count_r <= count_r + 32'd1;
                if (max_r < e_dur) max_r <= e_dur;
                if (min_r > e_dur) min_r <= e_dur;
              end
            end
            // entry lock need not be cleared: freed entries are skipped by the scan
            if (use_spin) spin_lock_r <= '0;
            else valid_r[hit_r] <= 1'b0;
          end else begin
            st_r <= lclm_pkg::ST_NOMATCH;
          end
        end
        S_OUT: ov_r <= 1'b1;
        default: ;
      endcase
    end
  end

  assign out_valid        = ov_r;
  assign out_status       = st_r;
  assign out_duration_ns  = dur_r;
  assign out_sample_count = count_r;
  assign out_total_ns     = total_r;
  assign out_min_ns       = min_r;
  assign out_max_ns       = max_r;
  assign out_last_flags   = flags_r;
endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Testbench for lock_contention_latency_monitor: directed table, table fill and drain,
// then random begin/end event sequences checked against a behavioural predictor. Uses lclm_pkg.
`timescale 1ns / 1ps
module tb_top;
  localparam int NUM_ENTRIES = 64;
  localparam int RAND_ITEMS  = 950;
  localparam int STALL_LIMIT = 4000;
  localparam int TASK_POOL   = 96;

  localparam logic [7:0] FLAG_SPIN  = lclm_pkg::FLAG_SPIN;
  localparam logic [7:0] FLAG_READ  = lclm_pkg::FLAG_READ;
  localparam logic [7:0] FLAG_WRITE = lclm_pkg::FLAG_WRITE;

  localparam logic [2:0] ST_BEGUN    = lclm_pkg::ST_BEGUN;
  localparam logic [2:0] ST_BUSY     = lclm_pkg::ST_BUSY;
  localparam logic [2:0] ST_FULL     = lclm_pkg::ST_FULL;
  localparam logic [2:0] ST_RECORDED = lclm_pkg::ST_RECORDED;
  localparam logic [2:0] ST_NOMATCH  = lclm_pkg::ST_NOMATCH;
  localparam logic [2:0] ST_NEGATIVE = lclm_pkg::ST_NEGATIVE;

  typedef struct {
    logic        op;
    logic [31:0] task_id;
    logic [63:0] lock;
    logic [7:0]  flags;
    logic [63:0] now;
  } lock_event_t;

  typedef struct {
    logic [2:0]  status;
    logic [63:0] duration;
    logic [31:0] count;
    logic [63:0] total;
    logic [63:0] min_v;
    logic [63:0] max_v;
    logic [7:0]  last_flags;
  } lock_stats_t;

  typedef struct {
    lock_event_t ev;
    logic        has_status;
    logic [2:0]  status;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_operation = 1'b0;
  logic [31:0] in_task_id = '0;
  logic [63:0] in_lock_addr = '0;
  logic [7:0]  in_lock_flags = '0;
  logic [63:0] in_now_ns = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [63:0] out_duration_ns;
  logic [31:0] out_sample_count;
  logic [63:0] out_total_ns;
  logic [63:0] out_min_ns;
  logic [63:0] out_max_ns;
  logic [7:0]  out_last_flags;

  lock_contention_latency_monitor #(.ENTRIES(NUM_ENTRIES)) i_dut (.*);

  always #2 clk = ~clk;

  // predictor state
  logic [63:0] p_spin_start, p_spin_lock;
  logic [7:0]  p_spin_kind;
  logic        p_valid [NUM_ENTRIES];
  logic [31:0] p_task  [NUM_ENTRIES];
  logic [63:0] p_start [NUM_ENTRIES];
  logic [63:0] p_lock  [NUM_ENTRIES];
  logic [7:0]  p_kind  [NUM_ENTRIES];
  logic [31:0] p_count;
  logic [63:0] p_total, p_min, p_max;
  logic [7:0]  p_flags;

  lock_stats_t expected_stats_q[$];
  int          mismatches = 0;
  int          status_seen [8];
  int          idle_cycles = 0;
  int          out_hold = 0;
  bit          quiet = 0;   // no idling on either side while set

  function automatic int find_task_slot(input logic [31:0] t);
    for (int i = 0; i < NUM_ENTRIES; i++)
      if (p_valid[i] && p_task[i] == t) return i;
    return -1;
  endfunction

  function automatic int find_free_slot();
    for (int i = 0; i < NUM_ENTRIES; i++)
      if (!p_valid[i]) return i;
    return -1;
  endfunction

  function automatic lock_stats_t predict_stats(input lock_event_t ev);
    lock_stats_t r;
    int idx;
    logic matched, use_spin;
    logic [63:0] st, d;
    logic [7:0] k;
    r.duration = '0;
    if (!ev.op) begin
      if (lclm_pkg::is_spin_kind(ev.flags)) begin
        if (p_spin_lock != 0) r.status = ST_BUSY;
        else begin
          p_spin_start = ev.now; p_spin_lock = ev.lock; p_spin_kind = ev.flags;
          r.status = ST_BEGUN;
        end
      end else begin
        idx = find_task_slot(ev.task_id);
        if (idx >= 0 && p_lock[idx] != 0) r.status = ST_BUSY;
        else begin
          if (idx < 0) begin
            idx = find_free_slot();
            if (idx >= 0) begin
              p_valid[idx] = 1'b1; p_task[idx] = ev.task_id;
            end
          end
          if (idx < 0) r.status = ST_FULL;
          else begin
            p_start[idx] = ev.now; p_lock[idx] = ev.lock; p_kind[idx] = ev.flags;
            r.status = ST_BEGUN;
          end
        end
      end
    end else begin
      use_spin = (p_spin_lock != 0);
      idx = -1; st = '0; k = '0;
      if (use_spin) begin
        matched = (p_spin_lock == ev.lock); st = p_spin_start; k = p_spin_kind;
      end else begin
        idx = find_task_slot(ev.task_id);
        matched = (idx >= 0) && (p_lock[idx] == ev.lock);
        if (matched) begin st = p_start[idx]; k = p_kind[idx]; end
      end
      if (!matched) r.status = ST_NOMATCH;
      else begin
        d = ev.now - st;
        if (d[63]) r.status = ST_NEGATIVE;
        else begin
          if (p_count == 32'd0) begin
            p_total = d; p_min = d; p_max = d; p_count = 32'd1;
          end else begin
            p_total += d;
            if (p_count != 32'hFFFF_FFFF) p_count++;
            if (p_max < d) p_max = d;
            if (p_min > d) p_min = d;
          end
          p_flags = k;
          r.duration = d;
          r.status = ST_RECORDED;
        end
        if (use_spin) p_spin_lock = '0;
        else begin p_lock[idx] = '0; p_valid[idx] = 1'b0; end
      end
    end
    r.count = p_count; r.total = p_total; r.min_v = p_min; r.max_v = p_max;
    r.last_flags = p_flags;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_event(input lock_event_t ev, input bit chk, input logic [2:0] st);
    int gap;
    lock_stats_t r;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_operation = ev.op; in_task_id = ev.task_id; in_lock_addr = ev.lock;
    in_lock_flags = ev.flags; in_now_ns = ev.now;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    r = predict_stats(ev);
    if (chk && r.status != st) begin
      mismatches++;
      if (mismatches <= 10)
        $display("directed item: predicted status %0d, table says %0d", r.status, st);
    end
    expected_stats_q.push_back(r);
    @(negedge clk);
  endtask

  // result side: stall at the falling edge for a drawn number of cycles
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_stall = 1'b1;
      out_hold--;
    end else out_stall = 1'b0;
  end

  always @(posedge clk) begin
    lock_stats_t e;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      out_hold = quiet ? 0 : $urandom_range(0, 19);
      if (expected_stats_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing expected");
      end else begin
        e = expected_stats_q.pop_front();
        status_seen[e.status]++;
        if (out_status !== e.status || out_duration_ns !== e.duration ||
            out_sample_count !== e.count || out_total_ns !== e.total ||
            out_min_ns !== e.min_v || out_max_ns !== e.max_v ||
            out_last_flags !== e.last_flags) begin
          mismatches++;
          if (mismatches <= 10)
            $display("exp st=%0d dur=%h cnt=%0d tot=%h min=%h max=%h fl=%h\n",
                     e.status, e.duration, e.count, e.total, e.min_v, e.max_v,
                     e.last_flags,
                     "got st=%0d dur=%h cnt=%0d tot=%h min=%h max=%h fl=%h",
                     out_status, out_duration_ns, out_sample_count, out_total_ns,
                     out_min_ns, out_max_ns, out_last_flags);
        end
      end
    end
  end

  function automatic lock_event_t mk(input logic op, input logic [31:0] t,
                                     input logic [63:0] l, input logic [7:0] f,
                                     input logic [63:0] n);
    lock_event_t ev;
    ev.op = op; ev.task_id = t; ev.lock = l; ev.flags = f; ev.now = n;
    return ev;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  lock_event_t   ev;
  directed_row_t rows[$];
  logic [63:0]   time_base;
  int            pick, idx;

  initial begin
    p_spin_start = '0; p_spin_lock = '0; p_spin_kind = '0;
    p_count = '0; p_total = '0; p_min = '0; p_max = '0; p_flags = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      p_valid[i] = 1'b0; p_task[i] = '0; p_start[i] = '0; p_lock[i] = '0; p_kind[i] = '0;
    end
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed table: status typed in only where obvious
    rows.push_back('{mk(1'b1, 32'd5, 64'h10, 8'h00, 64'd0), 1'b1, ST_NOMATCH});
    rows.push_back('{mk(1'b0, 32'd1, 64'hA0, FLAG_SPIN, 64'd100), 1'b1, ST_BEGUN});
    rows.push_back('{mk(1'b0, 32'd2, 64'hB0, FLAG_SPIN | FLAG_READ, 64'd110),
                     1'b1, ST_BUSY});
    rows.push_back('{mk(1'b1, 32'd1, 64'hB0, 8'h00, 64'd120), 1'b1, ST_NOMATCH});
    rows.push_back('{mk(1'b1, 32'd9, 64'hA0, 8'h00, 64'd150), 1'b0, ST_BEGUN});
    rows.push_back('{mk(1'b0, 32'd0, 64'd0, 8'h00, 64'd0), 1'b1, ST_BEGUN});
    rows.push_back('{mk(1'b1, 32'd0, 64'd0, 8'h00, 64'd5), 1'b0, ST_BEGUN});
    rows.push_back('{mk(1'b0, 32'hFFFF_FFFF, '1, 8'hFF, 64'h8000_0000_0000_0000),
                     1'b1, ST_BEGUN});
    rows.push_back('{mk(1'b0, 32'hFFFF_FFFF, 64'h1, FLAG_WRITE, 64'd7), 1'b1, ST_BUSY});
    // start at 2^63, end at 0: negative duration, entry still freed
    rows.push_back('{mk(1'b1, 32'hFFFF_FFFF, '1, 8'h00, 64'd0), 1'b1, ST_NEGATIVE});
    rows.push_back('{mk(1'b1, 32'hFFFF_FFFF, '1, 8'h00, 64'd9), 1'b1, ST_NOMATCH});
    rows.push_back('{mk(1'b0, 32'd3, 64'h1, FLAG_SPIN | FLAG_WRITE, '1), 1'b1, ST_BEGUN});
    rows.push_back('{mk(1'b1, 32'd3, 64'h1, 8'h00, 64'd0), 1'b0, ST_BEGUN});
    // spin begin with zero lock leaves the slot free
    rows.push_back('{mk(1'b0, 32'd4, 64'd0, FLAG_SPIN, 64'd50), 1'b1, ST_BEGUN});
    rows.push_back('{mk(1'b0, 32'd4, 64'h77, FLAG_SPIN, 64'd60), 1'b1, ST_BEGUN});
    rows.push_back('{mk(1'b1, 32'd4, 64'h77, 8'h00, 64'h7FFF_FFFF_FFFF_FFFF),
                     1'b0, ST_BEGUN});
    // zero-lock table entry overwritten by a real begin
    rows.push_back('{mk(1'b0, 32'd7, 64'd0, FLAG_READ, 64'd10), 1'b1, ST_BEGUN});
    rows.push_back('{mk(1'b0, 32'd7, 64'h9, FLAG_READ | FLAG_WRITE, 64'd20),
                     1'b1, ST_BEGUN});
    rows.push_back('{mk(1'b1, 32'd7, 64'h9, 8'h00, 64'd20), 1'b0, ST_BEGUN});
    rows.push_back('{mk(1'b0, 32'd8, 64'h5, FLAG_SPIN | FLAG_READ | FLAG_WRITE, 64'd1),
                     1'b1, ST_BEGUN});
    rows.push_back('{mk(1'b1, 32'd8, 64'h5, 8'h00, '1), 1'b0, ST_BEGUN});
    quiet = 1;
    foreach (rows[i]) send_event(rows[i].ev, rows[i].has_status, rows[i].status);
    quiet = 0;

    // fill the table past its capacity, then drain it
    for (int i = 0; i <= NUM_ENTRIES; i++)
      send_event(mk(1'b0, 32'h100 + i, 64'h1000 + i, FLAG_WRITE, 64'd1000 + i),
                 1'b0, ST_BEGUN);
    for (int i = 0; i <= NUM_ENTRIES; i++)
      send_event(mk(1'b1, 32'h100 + i, 64'h1000 + i, 8'h00, 64'd5000 + 3 * i),
                 1'b0, ST_BEGUN);

    time_base = 64'd1_000_000;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 2) begin
        in_valid = 1'b0;
        wait (expected_stats_q.size() == 0);
        @(negedge clk);
      end
      if (n % 200 == 0) quiet = ($urandom_range(0, 3) == 0);
      time_base += $urandom_range(0, 5000);
      if ($urandom_range(0, 49) == 0) time_base = rand64();
      pick = $urandom_range(0, 99);
      if (pick < ((n < RAND_ITEMS / 3) ? 55 : 40)) begin
        ev = mk(1'b0, $urandom_range(0, TASK_POOL - 1), rand64(), 8'($urandom()),
                time_base);
        if ($urandom_range(0, 2) == 0)
          ev.flags = ($urandom_range(0, 2) == 0) ? FLAG_SPIN :
                     ($urandom_range(0, 1) ? (FLAG_SPIN | FLAG_READ)
                                           : (FLAG_SPIN | FLAG_WRITE));
        if ($urandom_range(0, 19) == 0) ev.lock = '0;
      end else if (pick < 85) begin
        ev = mk(1'b1, $urandom_range(0, TASK_POOL - 1), rand64(), 8'($urandom()),
                time_base);
        if (p_spin_lock != 0 && $urandom_range(0, 3) != 0) begin
          ev.lock = p_spin_lock;
          ev.now = p_spin_start + $urandom_range(0, 100000);
        end else begin
          idx = $urandom_range(0, NUM_ENTRIES - 1);
          for (int j = 0; j < NUM_ENTRIES; j++)
            if (p_valid[(idx + j) % NUM_ENTRIES]) begin
              idx = (idx + j) % NUM_ENTRIES;
              ev.task_id = p_task[idx];
              ev.lock = p_lock[idx];
              ev.now = p_start[idx] + $urandom_range(0, 100000);
              break;
            end
        end
        if ($urandom_range(0, 9) == 0) ev.now = rand64();
      end else begin
        ev = mk(1'($urandom_range(0, 1)), $urandom(), rand64(), 8'($urandom()),
                rand64());
      end
      send_event(ev, 1'b0, ST_BEGUN);
    end
    in_valid = 1'b0;

    wait (expected_stats_q.size() == 0);
    repeat (100) @(posedge clk);
    $display("covered: begun %0d, busy %0d, full %0d, recorded %0d,",
             status_seen[ST_BEGUN], status_seen[ST_BUSY], status_seen[ST_FULL],
             status_seen[ST_RECORDED],
             " no match %0d, negative %0d",
             status_seen[ST_NOMATCH], status_seen[ST_NEGATIVE]);
    $display("mismatches %0d, results outstanding %0d", mismatches, expected_stats_q.size());
    if (mismatches == 0 && expected_stats_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// File: lock_contention_latency_monitor.f
sv/lclm_pkg.sv
sv/lclm_ram.sv
sv/lock_contention_latency_monitor.sv
verif/tb_top.sv
